### hdl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor engine package
// Shared types, codes and reset values of the cursor engine and its grid store.
// ----------------------------------------------------------------------------
`default_nettype none

package tcce_pkg;

    // Grid geometry defaults
    localparam int MAX_COLUMNS_DEFAULT = 256;
    localparam int MAX_LINES_DEFAULT   = 128;

    // One cell of the grid store: colour in the upper bits, character below
    localparam int CELL_W = 32;

    // Command codes carried on s_tuser
    typedef enum logic [1:0] {
        CMD_PUT   = 2'd0,
        CMD_SET   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_COLUMNS  = 3'd0,
        REG_ROWS     = 3'd1,
        REG_RESERVED = 3'd2,
        REG_COLOR    = 3'd3,
        REG_SCROLL   = 3'd4
    } reg_index_t;

    // Special character codes
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // Reset values of the configuration registers and the cursor
    localparam logic [8:0]  RST_COLUMNS  = 9'd80;
    localparam logic [7:0]  RST_ROWS     = 8'd25;
    localparam logic [6:0]  RST_RESERVED = 7'd2;
    localparam logic [23:0] RST_COLOR    = 24'hE8E8E8;
    localparam logic        RST_SCROLL   = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } state_t;

    // Result of one command, held until the output register is free
    typedef struct packed {
        logic        written;
        logic [6:0]  wrow;
        logic [7:0]  wcol;
        logic [7:0]  wch;
        logic [23:0] wcolor;
        logic        scrolled;
        logic        is_read;
        logic        rd_ok;
    } res_t;

endpackage

`default_nettype wire

### hdl/tcce_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module tcce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/text_console_cursor_engine_top.sv
// ----------------------------------------------------------------------------
// Text console cursor engine
// Cursor handling, character and colour grid, scrolling and clearing.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake               | Contents
//  --------+-----------+-------------------------+-------------------------------
//  s_      | in        | s_tvalid / s_tready     | command on tuser, cell in tdata
//  m_      | out       | m_tvalid / m_tready     | one result per command
//  cfg_    | in        | cfg_we (no back-pressure)| register index and value
//
//  An ordinary command is accepted and executed in ST_IDLE; its result waits
//  in ST_DONE and is loaded into the output register once that is free.
//  A scroll walks the grid through the single write port of the store, with
//  the effective register values: ST_SCROLL moves the rows up by one, and is
//  skipped when only the bottom row lies below the status area; ST_BLANK then
//  blanks the bottom row.
//  A clear, and the pass after reset, write every cell of the store once in
//  ST_CLEAR, during which no item is accepted.
//  A new item is accepted while an earlier result still waits on m_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cursor_engine_top #(
    parameter int MAX_COLUMNS = tcce_pkg::MAX_COLUMNS_DEFAULT,
    parameter int MAX_LINES   = tcce_pkg::MAX_LINES_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] char_code, [14:8] target_row, [22:15] target_col, [23] zero
    input  wire logic [23:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_tuser,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] cell_written, [7:1] written_row, [15:8] written_col,
    // [23:16] written_char, [47:24] written_color, [48] scrolled,
    // [55:49] cursor_row, [63:56] cursor_col, [71:64] read_char,
    // [95:72] read_color
    output logic [95:0]      m_tdata,

    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [23:0] cfg_wdata
);

    localparam int DEPTH  = MAX_LINES * MAX_COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [8:0]        MAXC      = 9'(MAX_COLUMNS);
    localparam logic [7:0]        MAXL      = 8'(MAX_LINES);

    // Control and configuration
    tcce_pkg::state_t state_reg, state_next;
    logic [8:0]  cols_cfg_reg, cols_cfg_next;
    logic [7:0]  rows_cfg_reg, rows_cfg_next;
    logic [6:0]  resv_cfg_reg, resv_cfg_next;
    logic [23:0] color_reg, color_next;
    logic        scroll_en_reg, scroll_en_next;

    logic [6:0]  cur_row_reg, cur_row_next;
    logic [7:0]  cur_col_reg, cur_col_next;

    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic              clr_res_reg, clr_res_next;
    logic [23:0]       clr_color_reg, clr_color_next;

    logic [6:0]        row_cnt_reg, row_cnt_next;
    logic [7:0]        col_cnt_reg, col_cnt_next;
    logic              rd_act_reg, rd_act_next;
    logic              mv_pend_reg, mv_pend_next;
    logic [ADDR_W-1:0] mv_addr_reg, mv_addr_next;

    tcce_pkg::res_t    res_reg, res_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [95:0]       m_tdata_reg, m_tdata_next;

    // Grid store port signals
    logic                       ram_we;
    logic [ADDR_W-1:0]          ram_waddr;
    logic [tcce_pkg::CELL_W-1:0] ram_wdata;
    logic                       ram_re;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [tcce_pkg::CELL_W-1:0] ram_rdata;

    // Effective geometry
    logic [8:0] eff_cols;
    logic [7:0] eff_rows;
    logic [6:0] eff_resv;
    logic [6:0] last_row;
    logic [7:0] last_col;

    // Row advance from the current cursor
    logic [7:0] row_inc;
    logic [6:0] adv_row;
    logic       adv_scroll;

    // Input fields
    tcce_pkg::cmd_t in_cmd;
    logic [7:0]     in_ch;
    logic [6:0]     in_row;
    logic [7:0]     in_col;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [6:0] row,
                                                    input logic [7:0] col);
        logic [15:0] lin;
        lin = 16'(row) * 16'(MAX_COLUMNS) + 16'(col);
        return lin[ADDR_W-1:0];
    endfunction

    tcce_ram #(
        .WIDTH (tcce_pkg::CELL_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_cmd = tcce_pkg::cmd_t'(s_tuser);
    assign in_ch  = s_tdata[7:0];
    assign in_row = s_tdata[14:8];
    assign in_col = s_tdata[22:15];

    assign eff_cols = (cols_cfg_reg == 9'd0) ? 9'd1 :
                      (cols_cfg_reg > MAXC) ? MAXC : cols_cfg_reg;
    assign eff_rows = (rows_cfg_reg == 8'd0) ? 8'd1 :
                      (rows_cfg_reg > MAXL) ? MAXL : rows_cfg_reg;
    assign last_row = 7'(eff_rows - 8'd1);
    assign last_col = 8'(eff_cols - 9'd1);
    assign eff_resv = ({1'b0, resv_cfg_reg} < eff_rows) ? resv_cfg_reg : last_row;

    assign row_inc    = {1'b0, cur_row_reg} + 8'd1;
    assign adv_scroll = (row_inc >= eff_rows) && scroll_en_reg;
    assign adv_row    = (row_inc >= eff_rows) ? last_row : row_inc[6:0];

    assign s_tready = (state_reg == tcce_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb begin
        logic [8:0]  col_inc;
        logic [7:0]  col_dec;
        logic [7:0]  first_src;
        logic        do_scroll;
        logic [7:0]  rd_ch;
        logic [23:0] rd_color;

        state_next     = state_reg;
        cols_cfg_next  = cols_cfg_reg;
        rows_cfg_next  = rows_cfg_reg;
        resv_cfg_next  = resv_cfg_reg;
        color_next     = color_reg;
        scroll_en_next = scroll_en_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_res_next   = clr_res_reg;
        clr_color_next = clr_color_reg;
        row_cnt_next   = row_cnt_reg;
        col_cnt_next   = col_cnt_reg;
        rd_act_next    = rd_act_reg;
        mv_pend_next   = mv_pend_reg;
        mv_addr_next   = mv_addr_reg;
        res_next       = res_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_tdata_next   = m_tdata_reg;

        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        col_inc   = {1'b0, cur_col_reg} + 9'd1;
        col_dec   = cur_col_reg - 8'd1;
        first_src = {1'b0, eff_resv} + 8'd1;
        do_scroll = 1'b0;
        rd_ch     = 8'd0;
        rd_color  = 24'd0;

        if (cfg_we) begin
            unique case (cfg_index)
                tcce_pkg::REG_COLUMNS:  cols_cfg_next  = cfg_wdata[8:0];
                tcce_pkg::REG_ROWS:     rows_cfg_next  = cfg_wdata[7:0];
                tcce_pkg::REG_RESERVED: resv_cfg_next  = cfg_wdata[6:0];
                tcce_pkg::REG_COLOR:    color_next     = cfg_wdata;
                tcce_pkg::REG_SCROLL:   scroll_en_next = cfg_wdata[0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            tcce_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = {clr_color_reg, tcce_pkg::CH_BLANK};
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ADDR) begin
                    state_next = clr_res_reg ? tcce_pkg::ST_DONE : tcce_pkg::ST_IDLE;
                end
            end

            tcce_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    res_next         = '0;
                    res_next.is_read = (in_cmd == tcce_pkg::CMD_READ);
                    state_next       = tcce_pkg::ST_DONE;
                    unique case (in_cmd)
                        tcce_pkg::CMD_PUT: begin
                            if (in_ch == tcce_pkg::CH_CR) begin
                                cur_col_next = 8'd0;
                            end else if (in_ch == tcce_pkg::CH_LF) begin
                                cur_col_next = 8'd0;
                                cur_row_next = adv_row;
                                do_scroll    = adv_scroll;
                            end else if (in_ch == tcce_pkg::CH_BS ||
                                         in_ch == tcce_pkg::CH_DEL) begin
                                if (cur_col_reg != 8'd0) begin
                                    cur_col_next = col_dec;
                                    if ({1'b0, cur_row_reg} < MAXL &&
                                        {1'b0, col_dec} < MAXC) begin
                                        ram_we          = 1'b1;
                                        ram_waddr       = cell_addr(cur_row_reg, col_dec);
                                        ram_wdata       = {color_reg, tcce_pkg::CH_BLANK};
                                        res_next.written = 1'b1;
                                        res_next.wrow   = cur_row_reg;
                                        res_next.wcol   = col_dec;
                                        res_next.wch    = tcce_pkg::CH_BLANK;
                                        res_next.wcolor = color_reg;
                                    end
                                end
                            end else begin
                                if ({1'b0, cur_row_reg} < MAXL &&
                                    {1'b0, cur_col_reg} < MAXC) begin
                                    ram_we          = 1'b1;
                                    ram_waddr       = cell_addr(cur_row_reg, cur_col_reg);
                                    ram_wdata       = {color_reg, in_ch};
                                    res_next.written = 1'b1;
                                    res_next.wrow   = cur_row_reg;
                                    res_next.wcol   = cur_col_reg;
                                    res_next.wch    = in_ch;
                                    res_next.wcolor = color_reg;
                                end
                                if (col_inc >= eff_cols) begin
                                    cur_col_next = 8'd0;
                                    cur_row_next = adv_row;
                                    do_scroll    = adv_scroll;
                                end else begin
                                    cur_col_next = col_inc[7:0];
                                end
                            end

                            if (do_scroll) begin
                                res_next.scrolled = 1'b1;
                                row_cnt_next = first_src[6:0];
                                col_cnt_next = 8'd0;
                                mv_pend_next = 1'b0;
                                // Nothing to move when the status area reaches
                                // the row above the bottom row: only the blanking remains.
                                if (first_src >= eff_rows) begin
                                    rd_act_next = 1'b0;
                                    state_next  = tcce_pkg::ST_BLANK;
                                end else begin
                                    rd_act_next = 1'b1;
                                    state_next  = tcce_pkg::ST_SCROLL;
                                end
                            end
                        end

                        tcce_pkg::CMD_SET: begin
                            cur_row_next = ({1'b0, in_row} >= eff_rows) ? last_row : in_row;
                            cur_col_next = ({1'b0, in_col} >= eff_cols) ? last_col : in_col;
                        end

                        tcce_pkg::CMD_READ: begin
                            ram_re         = 1'b1;
                            ram_raddr      = cell_addr(in_row, in_col);
                            res_next.rd_ok = ({1'b0, in_row} < MAXL) &&
                                             ({1'b0, in_col} < MAXC);
                        end

                        tcce_pkg::CMD_CLEAR: begin
                            cur_row_next   = eff_resv;
                            cur_col_next   = 8'd0;
                            clr_cnt_next   = '0;
                            clr_res_next   = 1'b1;
                            clr_color_next = color_reg;
                            state_next     = tcce_pkg::ST_CLEAR;
                        end

                        default: ;
                    endcase
                end
            end

            tcce_pkg::ST_SCROLL: begin
                // Read one cell per cycle and write it one row up in the next cycle
                if (mv_pend_reg) begin
                    ram_we    = 1'b1;
                    ram_waddr = mv_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (rd_act_reg) begin
                    ram_re       = 1'b1;
                    ram_raddr    = cell_addr(row_cnt_reg, col_cnt_reg);
                    mv_pend_next = 1'b1;
                    mv_addr_next = cell_addr(row_cnt_reg - 7'd1, col_cnt_reg);
                    if (col_cnt_reg == last_col) begin
                        col_cnt_next = 8'd0;
                        if (row_cnt_reg == last_row) begin
                            rd_act_next = 1'b0;
                        end else begin
                            row_cnt_next = row_cnt_reg + 7'd1;
                        end
                    end else begin
                        col_cnt_next = col_cnt_reg + 8'd1;
                    end
                end else begin
                    mv_pend_next = 1'b0;
                    col_cnt_next = 8'd0;
                    state_next   = tcce_pkg::ST_BLANK;
                end
            end

            tcce_pkg::ST_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(last_row, col_cnt_reg);
                ram_wdata = {color_reg, tcce_pkg::CH_BLANK};
                col_cnt_next = col_cnt_reg + 8'd1;
                if (col_cnt_reg == last_col) begin
                    state_next = tcce_pkg::ST_DONE;
                end
            end

            tcce_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    if (res_reg.is_read && res_reg.rd_ok) begin
                        rd_ch    = ram_rdata[7:0];
                        rd_color = ram_rdata[31:8];
                    end
                    m_tdata_next  = {rd_color, rd_ch, cur_col_reg, cur_row_reg,
                                     res_reg.scrolled, res_reg.wcolor, res_reg.wch,
                                     res_reg.wcol, res_reg.wrow, res_reg.written};
                    m_tvalid_next = 1'b1;
                    clr_res_next  = 1'b0;
                    state_next    = tcce_pkg::ST_IDLE;
                end
            end

            default: state_next = tcce_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tcce_pkg::ST_CLEAR;
            cols_cfg_reg  <= tcce_pkg::RST_COLUMNS;
            rows_cfg_reg  <= tcce_pkg::RST_ROWS;
            resv_cfg_reg  <= tcce_pkg::RST_RESERVED;
            color_reg     <= tcce_pkg::RST_COLOR;
            scroll_en_reg <= tcce_pkg::RST_SCROLL;
            cur_row_reg   <= tcce_pkg::RST_RESERVED;
            cur_col_reg   <= 8'd0;
            clr_cnt_reg   <= '0;
            clr_res_reg   <= 1'b0;
            clr_color_reg <= tcce_pkg::RST_COLOR;
            rd_act_reg    <= 1'b0;
            mv_pend_reg   <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cols_cfg_reg  <= cols_cfg_next;
            rows_cfg_reg  <= rows_cfg_next;
            resv_cfg_reg  <= resv_cfg_next;
            color_reg     <= color_next;
            scroll_en_reg <= scroll_en_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_res_reg   <= clr_res_next;
            clr_color_reg <= clr_color_next;
            rd_act_reg    <= rd_act_next;
            mv_pend_reg   <= mv_pend_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        row_cnt_reg <= row_cnt_next;
        col_cnt_reg <= col_cnt_next;
        mv_addr_reg <= mv_addr_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire
